/* hw/rtl/brrc_pkg.sv */
// Shared types and constants for the box range relation check.
// No dependencies; imported by every module of the block.
`default_nettype none

package brrc_pkg;

	// Defaults for the top-level parameters
	localparam int DIMS_DEF        = 2;
	localparam int VALUE_BYTES_DEF = 8;

	// Dimensions carried on the item and configuration ports
	localparam int CARRIED_DIMS = 2;
	localparam int PORT_W       = 64;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_MIN_0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_MAX_0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_MIN_1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_MAX_1 = 3'd5;

	// Query modes; the unused code behaves as inclusive range
	localparam logic [1:0] MODE_LESS    = 2'd0;
	localparam logic [1:0] MODE_GREATER = 2'd1;
	localparam logic [1:0] MODE_RANGE   = 2'd2;

	// Commands
	localparam logic CMD_CELL  = 1'b0;
	localparam logic CMD_POINT = 1'b1;

	// Relation codes
	localparam logic [1:0] REL_OUTSIDE  = 2'd0;
	localparam logic [1:0] REL_INSIDE   = 2'd1;
	localparam logic [1:0] REL_CROSSES  = 2'd2;
	localparam logic [1:0] REL_NO_MATCH = 2'd0;
	localparam logic [1:0] REL_MATCH    = 2'd1;

	// Magnitude comparisons of one dimension against the query bounds
	typedef struct packed {
		logic lo_lt_min;
		logic lo_eq_min;
		logic lo_lt_max;
		logic lo_eq_max;
		logic hi_lt_min;
		logic hi_eq_min;
		logic hi_lt_max;
		logic hi_eq_max;
	} cmp_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/brrc_cmp.sv */
// Per-dimension comparator: cell bounds against query bounds.
// Depends on brrc_pkg for the flag struct.
`default_nettype none

module brrc_cmp #(
	parameter int VALUE_BYTES = brrc_pkg::VALUE_BYTES_DEF
) (
	input  wire logic [8*VALUE_BYTES-1:0] lo,
	input  wire logic [8*VALUE_BYTES-1:0] hi,
	input  wire logic [8*VALUE_BYTES-1:0] qmin,
	input  wire logic [8*VALUE_BYTES-1:0] qmax,
	output brrc_pkg::cmp_flags_t          flags
);
	import brrc_pkg::*;

	always_comb begin
		flags.lo_lt_min = lo < qmin;
		flags.lo_eq_min = lo == qmin;
		flags.lo_lt_max = lo < qmax;
		flags.lo_eq_max = lo == qmax;
		flags.hi_lt_min = hi < qmin;
		flags.hi_eq_min = hi == qmin;
		flags.hi_lt_max = hi < qmax;
		flags.hi_eq_max = hi == qmax;
	end

endmodule

`default_nettype wire

/* hw/rtl/box_range_relation_check.sv */
// Top level of the box range relation check: config registers and pipeline.
// Depends on brrc_pkg and brrc_cmp.
`default_nettype none

// Compares a cell box or a point with the configured query box and returns one
// relation per transaction. Three register stages (input capture, comparison,
// classification): result_valid is the valid bit of the classification stage, and
// throughput is one transaction per cycle while result_stall is low. A stage moves
// whenever the stage after it is empty or moving, so
// item_stall rises only when all three stages hold a transaction and result_stall
// is high. Configuration must only be written while the pipeline is empty. Only
// the low 8*VALUE_BYTES bits of coordinates and bounds are compared; at most
// min(DIMS, 2) dimensions take part.
module box_range_relation_check #(
	parameter int DIMS        = brrc_pkg::DIMS_DEF,
	parameter int VALUE_BYTES = brrc_pkg::VALUE_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_write,
	input  wire logic [brrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [brrc_pkg::PORT_W-1:0]    cfg_data,
	// items
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire logic                           command,
	input  wire logic [brrc_pkg::PORT_W-1:0]    low_0,
	input  wire logic [brrc_pkg::PORT_W-1:0]    high_0,
	input  wire logic [brrc_pkg::PORT_W-1:0]    low_1,
	input  wire logic [brrc_pkg::PORT_W-1:0]    high_1,
	// results
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic [1:0]                          relation
);
	import brrc_pkg::*;

	localparam int VW    = 8 * VALUE_BYTES;
	localparam int LANES = (DIMS < CARRIED_DIMS) ? DIMS : CARRIED_DIMS;

	// Configuration registers
	logic [1:0]    mode_q;
	logic [1:0]    dim_count_q;
	logic [VW-1:0] qmin_q [LANES];
	logic [VW-1:0] qmax_q [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_RANGE;
			dim_count_q <= 2'd1;
			for (int d = 0; d < LANES; d++) begin
				qmin_q[d] <= '0;
				qmax_q[d] <= '1;
			end
		end else if (cfg_write) begin
			if (cfg_index == REG_QUERY_MODE) begin
				mode_q <= cfg_data[1:0];
			end
			if (cfg_index == REG_DIM_COUNT) begin
				dim_count_q <= cfg_data[1:0];
			end
			for (int d = 0; d < LANES; d++) begin
				if (cfg_index == REG_QUERY_MIN_0 + CFG_IDX_W'(2 * d)) begin
					qmin_q[d] <= cfg_data[VW-1:0];
				end
				if (cfg_index == REG_QUERY_MAX_0 + CFG_IDX_W'(2 * d)) begin
					qmax_q[d] <= cfg_data[VW-1:0];
				end
			end
		end
	end

	// Stage advance: a stage loads when it is empty or its content moves on
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	assign adv3       = !v_s3 || !result_stall;
	assign adv2       = !v_s2 || adv3;
	assign adv1       = !v_s1 || adv2;
	assign item_stall = !adv1;

	logic [VW-1:0] lo_in [CARRIED_DIMS];
	logic [VW-1:0] hi_in [CARRIED_DIMS];

	assign lo_in[0] = low_0[VW-1:0];
	assign hi_in[0] = high_0[VW-1:0];
	assign lo_in[1] = low_1[VW-1:0];
	assign hi_in[1] = high_1[VW-1:0];

	// Stage 1: capture
	logic          cmd_s1;
	logic [VW-1:0] lo_s1 [LANES];
	logic [VW-1:0] hi_s1 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && item_valid) begin
			cmd_s1 <= command;
			for (int d = 0; d < LANES; d++) begin
				lo_s1[d] <= lo_in[d];
				hi_s1[d] <= hi_in[d];
			end
		end
	end

	// Stage 2: comparisons
	cmp_flags_t flags_c  [LANES];
	cmp_flags_t flags_s2 [LANES];
	logic       cmd_s2;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		brrc_cmp #(
			.VALUE_BYTES(VALUE_BYTES)
		) u_cmp (
			.lo   (lo_s1[g]),
			.hi   (hi_s1[g]),
			.qmin (qmin_q[g]),
			.qmax (qmax_q[g]),
			.flags(flags_c[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			cmd_s2 <= cmd_s1;
			for (int d = 0; d < LANES; d++) begin
				flags_s2[d] <= flags_c[d];
			end
		end
	end

	// Stage 3: classification
	logic [1:0] n_active;
	logic       outside_c, cross_c, fail_c;
	logic [1:0] relation_c;
	logic [1:0] relation_s3;

	always_comb begin
		n_active = (dim_count_q > 2'(LANES)) ? 2'(LANES) : dim_count_q;
		outside_c = 1'b0;
		cross_c   = 1'b0;
		fail_c    = 1'b0;
		for (int d = 0; d < LANES; d++) begin
			if (2'(d) < n_active) begin
				unique case (mode_q)
					MODE_LESS: begin
						outside_c |= !flags_s2[d].lo_lt_max;
						fail_c    |= !flags_s2[d].lo_lt_max;
						cross_c   |= flags_s2[d].lo_lt_min || flags_s2[d].lo_eq_min
							|| !flags_s2[d].hi_lt_max;
					end
					MODE_GREATER: begin
						outside_c |= flags_s2[d].hi_lt_min || flags_s2[d].hi_eq_min;
						fail_c    |= flags_s2[d].lo_lt_min || flags_s2[d].lo_eq_min;
						cross_c   |= flags_s2[d].lo_lt_min || flags_s2[d].lo_eq_min
							|| !flags_s2[d].hi_lt_max;
					end
					default: begin
						// inclusive range, also for the unused mode code
						outside_c |= !(flags_s2[d].lo_lt_max || flags_s2[d].lo_eq_max)
							|| flags_s2[d].hi_lt_min;
						fail_c    |= flags_s2[d].lo_lt_min
							|| !(flags_s2[d].lo_lt_max || flags_s2[d].lo_eq_max);
						cross_c   |= flags_s2[d].lo_lt_min
							|| !(flags_s2[d].hi_lt_max || flags_s2[d].hi_eq_max);
					end
				endcase
			end
		end
		// an outside dimension anywhere wins over crossing
		if (cmd_s2 == CMD_POINT) begin
			relation_c = fail_c ? REL_NO_MATCH : REL_MATCH;
		end else if (outside_c) begin
			relation_c = REL_OUTSIDE;
		end else begin
			relation_c = cross_c ? REL_CROSSES : REL_INSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			relation_s3 <= relation_c;
		end
	end

	assign result_valid = v_s3;
	assign relation     = relation_s3;

endmodule

`default_nettype wire

/* hw/rtl/brrc_check.sv */
// Port-level checks for box_range_relation_check, bound to the top level.
// Depends on brrc_pkg for the relation codes.
`default_nettype none

module brrc_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_stall,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic [1:0] relation
);
	import brrc_pkg::*;

	// a waiting result is held until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(relation))
		else $error("result dropped or changed while stalled");

	// no relation code above crossing
	a_relation_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> relation == REL_OUTSIDE || relation == REL_INSIDE
			|| relation == REL_CROSSES)
		else $error("relation code out of range");

	// input back-pressure only when the pipeline is full and the output blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled with room in the pipeline");

	// an accepted transaction passes capture, comparison and classification while the output keeps draining
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) ##1 !result_stall ##1 !result_stall |=> result_valid)
		else $error("transaction did not reach the output in three cycles");

endmodule

bind box_range_relation_check brrc_check u_brrc_check (.*);

`default_nettype wire
